### src/bpr_pkg.sv
// Shared types, constants and helpers for the block permutation reorder.
package bpr_pkg;

  localparam int BLEN_W    = 5;
  localparam int PERM_W    = 4;
  localparam int MAP_W     = 64;
  localparam int POS_W     = 32;
  localparam int REF_W     = 17;
  localparam int REF_MAG_W = 16;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;

  // remainder unit: bits retired per cycle, iterations per remainder
  localparam int REM_STEPS  = 4;
  localparam int REM_CYCLES = REF_MAG_W / REM_STEPS;
  localparam int REM_CNT_W  = $clog2(REM_CYCLES);

  localparam logic [BLEN_W-1:0]    BLEN_RESET = 5'd1;
  localparam logic [MAP_W-1:0]     PERM_RESET = 64'hFEDC_BA98_7654_3210;
  localparam logic signed [REF_W-1:0] REF_NONE = -17'sd1;
  localparam logic [REF_W-1:0]     REF_SAT    = 17'd65535;
  localparam logic [POS_W-1:0]     POS_NONE   = 32'd0;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_PERM = 2'd1,
    ST_NOT_DIV  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_LEN = 2'd0,
    REG_PERM_MAP  = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [POS_W-1:0]        position;
    logic signed [REF_W-1:0] ref_id;
  } entry_t;

  function automatic logic [PERM_W-1:0] perm_entry(input logic [MAP_W-1:0] map,
                                                   input logic [PERM_W-1:0] idx);
    perm_entry = map[idx*PERM_W +: PERM_W];
  endfunction

endpackage

### src/bpr_in_if.sv
// Input item channel.
interface bpr_in_if;
  logic                             valid;
  logic                             ready;
  logic [bpr_pkg::POS_W-1:0]        position_id;
  logic signed [bpr_pkg::REF_W-1:0] ref_id;
  logic                             stream_end;

  modport source(output valid, position_id, ref_id, stream_end, input ready);
  modport sink(input valid, position_id, ref_id, stream_end, output ready);
endinterface

### src/bpr_out_if.sv
// Result channel.
interface bpr_out_if;
  logic                             valid;
  logic                             ready;
  logic [bpr_pkg::POS_W-1:0]        out_position;
  logic signed [bpr_pkg::REF_W-1:0] out_ref;
  logic                             block_last;
  logic [bpr_pkg::STATUS_W-1:0]     status;

  modport source(output valid, out_position, out_ref, block_last, status, input ready);
  modport sink(input valid, out_position, out_ref, block_last, status, output ready);
endinterface

### src/bpr_cfg_if.sv
// Register write channel.
interface bpr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bpr_pkg::CFG_IDX_W-1:0]   index;
  logic [bpr_pkg::MAP_W-1:0]       data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### src/bpr_rem.sv
// Iterative remainder unit: dividend mod divisor, REM_STEPS bits per cycle.
module bpr_rem (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [bpr_pkg::REF_MAG_W-1:0]  dividend,
  input  logic [bpr_pkg::BLEN_W-1:0]     divisor,
  output logic                           done,
  output logic [bpr_pkg::BLEN_W-1:0]     rem
);

  logic                           busy;
  logic [bpr_pkg::REM_CNT_W-1:0]  cnt;
  logic [bpr_pkg::REF_MAG_W-1:0]  shreg;
  logic [bpr_pkg::REF_MAG_W-1:0]  shreg_next;
  logic [bpr_pkg::BLEN_W-1:0]     rem_next;
  logic [bpr_pkg::BLEN_W:0]       trial;

  // restoring steps; remainder stays below the divisor
  always_comb begin
    rem_next   = rem;
    shreg_next = shreg;
    trial      = '0;
    for (int k = 0; k < bpr_pkg::REM_STEPS; k++) begin
      trial      = {rem_next, shreg_next[bpr_pkg::REF_MAG_W-1]};
      shreg_next = {shreg_next[bpr_pkg::REF_MAG_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        trial = trial - {1'b0, divisor};
      end
      rem_next = trial[bpr_pkg::BLEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == bpr_pkg::REM_CNT_W'(bpr_pkg::REM_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
    end else if (busy) begin
      shreg <= shreg_next;
      rem   <= rem_next;
    end
  end

endmodule

### src/bpr_store.sv
// Block store: one write port, one registered read port.
module bpr_store #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [IDX_W-1:0]      waddr,
  input  bpr_pkg::entry_t       wdata,
  input  logic                  re,
  input  logic [IDX_W-1:0]      raddr,
  output bpr_pkg::entry_t       rdata
);

  bpr_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/block_permutation_reorder.sv
// Block permutation reorder: gathers items into blocks and emits them permuted.
//
// Channels: items (valid/ready, position_id, ref_id, stream_end) in,
// results (valid/ready, out_position, out_ref, block_last, status) out,
// cfg (valid/ready, index, data) writes block_len (0) or perm_map (1).
// Any cfg write clears the partial block; cfg is always ready.
// An item that completes no block, hits no bad slot and does not end the
// stream is taken and gives no word. The item that completes a block of n
// starts emission: each result word takes a store read, a setup step, the
// remainder unit (ref mod n, four bits per cycle; skipped for a negative
// reference) and a load of the output register, and waits while the
// receiver stalls. Bad slot and early stream end give one error word,
// valid in the cycle after the item is taken.
// Items are not accepted while a block is emitted or a word is waiting;
// a stalled receiver simply holds the word and the sequencer.
// Reset: block_len 1, identity perm_map, empty block, no word pending.
module block_permutation_reorder #(
  parameter int MAX_BLOCK = 16
) (
  input  logic        clk,
  input  logic        rst,
  bpr_in_if.sink      items,
  bpr_out_if.source   results,
  bpr_cfg_if.sink     cfg
);

  localparam int IDX_W = $clog2(MAX_BLOCK);
  localparam int CNT_W = $clog2(MAX_BLOCK + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_START = 5'b00100,
    S_REM   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t                           state;
  logic [bpr_pkg::BLEN_W-1:0]       block_len;
  logic [bpr_pkg::MAP_W-1:0]        perm_map;
  logic [MAX_BLOCK-1:0]             slot_used;
  logic [CNT_W-1:0]                 fill_count;
  logic [IDX_W-1:0]                 emit_idx;
  logic                             emitting;

  logic [bpr_pkg::POS_W-1:0]        out_position;
  logic signed [bpr_pkg::REF_W-1:0] out_ref;
  logic                             out_last;
  bpr_pkg::status_t                 out_status;

  logic [CNT_W-1:0]                 n;
  logic [bpr_pkg::PERM_W-1:0]       slot;
  logic                             bad_slot;
  logic                             block_full;
  logic                             in_take;
  logic                             idx_last;
  bpr_pkg::entry_t                  wr_entry;
  bpr_pkg::entry_t                  rd_entry;
  logic                             rd_neg;
  logic                             rem_start;
  logic                             rem_done;
  logic [bpr_pkg::BLEN_W-1:0]       rem_val;
  logic [bpr_pkg::REF_W-1:0]        remapped;
  logic signed [bpr_pkg::REF_W-1:0] ref_sat;

  // effective block length
  always_comb begin
    if (block_len == '0) begin
      n = CNT_W'(1);
    end else if (block_len > bpr_pkg::BLEN_W'(MAX_BLOCK)) begin
      n = CNT_W'(MAX_BLOCK);
    end else begin
      n = CNT_W'(block_len);
    end
  end

  assign slot       = bpr_pkg::perm_entry(perm_map, bpr_pkg::PERM_W'(fill_count));
  assign bad_slot   = ({1'b0, slot} >= bpr_pkg::BLEN_W'(n)) || slot_used[slot[IDX_W-1:0]];
  assign block_full = (fill_count + CNT_W'(1)) == n;
  assign in_take    = items.valid && items.ready;
  assign idx_last   = CNT_W'(emit_idx) == (n - CNT_W'(1));

  assign items.ready = (state == S_IDLE);
  assign cfg.ready   = 1'b1;

  assign wr_entry.position = items.position_id;
  assign wr_entry.ref_id   = items.ref_id;

  bpr_store #(
    .DEPTH (MAX_BLOCK),
    .IDX_W (IDX_W)
  ) u_store (
    .clk   (clk),
    .we    (in_take && !bad_slot),
    .waddr (slot[IDX_W-1:0]),
    .wdata (wr_entry),
    .re    (state == S_READ),
    .raddr (emit_idx),
    .rdata (rd_entry)
  );

  assign rd_neg    = rd_entry.ref_id[bpr_pkg::REF_W-1];
  assign rem_start = (state == S_START) && !rd_neg;

  bpr_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (rd_entry.ref_id[bpr_pkg::REF_MAG_W-1:0]),
    .divisor  (bpr_pkg::BLEN_W'(n)),
    .done     (rem_done),
    .rem      (rem_val)
  );

  // ref - (ref mod n) + perm[ref mod n], saturated
  assign remapped = {1'b0, rd_entry.ref_id[bpr_pkg::REF_MAG_W-1:0]}
                  - bpr_pkg::REF_W'(rem_val)
                  + bpr_pkg::REF_W'(bpr_pkg::perm_entry(perm_map,
                                      rem_val[bpr_pkg::PERM_W-1:0]));
  assign ref_sat  = (remapped > bpr_pkg::REF_SAT) ? bpr_pkg::REF_SAT : remapped;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      block_len  <= bpr_pkg::BLEN_RESET;
      perm_map   <= bpr_pkg::PERM_RESET;
      slot_used  <= '0;
      fill_count <= '0;
      emit_idx   <= '0;
      emitting   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_take) begin
            if (bad_slot) begin
              slot_used  <= '0;
              fill_count <= '0;
              emitting   <= 1'b0;
              state      <= S_OUT;
            end else if (block_full) begin
              slot_used  <= '0;
              fill_count <= '0;
              emit_idx   <= '0;
              emitting   <= 1'b1;
              state      <= S_READ;
            end else if (items.stream_end) begin
              slot_used  <= '0;
              fill_count <= '0;
              emitting   <= 1'b0;
              state      <= S_OUT;
            end else begin
              slot_used[slot[IDX_W-1:0]] <= 1'b1;
              fill_count <= fill_count + CNT_W'(1);
            end
          end
        end
        S_READ: begin
          state <= S_START;
        end
        S_START: begin
          state <= rd_neg ? S_OUT : S_REM;
        end
        S_REM: begin
          if (rem_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (results.ready) begin
            if (emitting && !idx_last) begin
              emit_idx <= emit_idx + IDX_W'(1);
              state    <= S_READ;
            end else begin
              emitting <= 1'b0;
              state    <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (cfg.valid) begin
        case (cfg.index)
          bpr_pkg::REG_BLOCK_LEN: block_len <= cfg.data[bpr_pkg::BLEN_W-1:0];
          bpr_pkg::REG_PERM_MAP:  perm_map  <= cfg.data;
          default: ;
        endcase
        slot_used  <= '0;
        fill_count <= '0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_take && (bad_slot || (!block_full && items.stream_end))) begin
      out_position <= bpr_pkg::POS_NONE;
      out_ref      <= bpr_pkg::REF_NONE;
      out_last     <= 1'b1;
      out_status   <= bad_slot ? bpr_pkg::ST_BAD_PERM : bpr_pkg::ST_NOT_DIV;
    end else if ((state == S_START && rd_neg) || (state == S_REM && rem_done)) begin
      out_position <= rd_entry.position;
      out_ref      <= rd_neg ? rd_entry.ref_id : ref_sat;
      out_last     <= idx_last;
      out_status   <= bpr_pkg::ST_OK;
    end
  end

  assign results.valid        = (state == S_OUT);
  assign results.out_position = out_position;
  assign results.out_ref      = out_ref;
  assign results.block_last   = out_last;
  assign results.status       = out_status;

endmodule

### src/bpr_checker.sv
// Port-level checks for the block permutation reorder, bound to the top level.
module bpr_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [bpr_pkg::POS_W-1:0]        out_position,
  input logic signed [bpr_pkg::REF_W-1:0] out_ref,
  input logic                             block_last,
  input logic [bpr_pkg::STATUS_W-1:0]     status
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_position) && $stable(out_ref)
      && $stable(block_last) && $stable(status))
    else $error("result word changed while stalled");

  // error words carry the fixed payload and end the block
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == bpr_pkg::ST_BAD_PERM || status == bpr_pkg::ST_NOT_DIV)
      |-> block_last && out_position == bpr_pkg::POS_NONE && out_ref == bpr_pkg::REF_NONE)
    else $error("error word with bad payload");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == bpr_pkg::ST_OK || status == bpr_pkg::ST_BAD_PERM
      || status == bpr_pkg::ST_NOT_DIV))
    else $error("unknown status code");

  // no new item while a word is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while a result is pending");

  // an ok word with a reference never exceeds the reference range
  a_ref_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == bpr_pkg::ST_OK && !out_ref[bpr_pkg::REF_W-1]
      |-> out_ref <= $signed(bpr_pkg::REF_SAT))
    else $error("remapped reference out of range");

endmodule

bind block_permutation_reorder bpr_checker u_bpr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (items.ready),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .out_position (results.out_position),
  .out_ref      (results.out_ref),
  .block_last   (results.block_last),
  .status       (results.status)
);

### dv/tb.sv
// Testbench for block_permutation_reorder: directed and random traffic against a scoreboard.
`timescale 1ns / 1ps

module tb;
  import bpr_pkg::*;

  localparam int          RANDOM_ITEMS  = 410;
  localparam int          SETTLE_CYCLES = 16;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int          SLOTS         = 16;

  // indexes with no register behind them; a write still clears the block
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef struct {
    logic [POS_W-1:0]        pos;
    logic signed [REF_W-1:0] rid;
    logic                    last;
    status_t                 st;
  } result_word_t;

  logic clk;
  logic rst;

  bpr_in_if  in_ch();
  bpr_out_if out_ch();
  bpr_cfg_if cfg_ch();

  block_permutation_reorder u_top (
    .clk     (clk),
    .rst     (rst),
    .items   (in_ch),
    .results (out_ch),
    .cfg     (cfg_ch)
  );

  // shadow of the block
  logic [BLEN_W-1:0]       blk_len_reg;
  logic [MAP_W-1:0]        perm_reg;
  logic [POS_W-1:0]        store_pos [SLOTS];
  logic signed [REF_W-1:0] store_ref [SLOTS];
  logic [SLOTS-1:0]        slot_mask;
  int unsigned             fill;

  result_word_t permuted_words[$];

  bit calm;
  int fail_count;
  int items_sent;
  int reg_writes;
  int ok_words;
  int bad_slot_words;
  int early_end_words;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned eff_len();
    if (blk_len_reg == 0) return 1;
    if (blk_len_reg > SLOTS) return SLOTS;
    return 32'(blk_len_reg);
  endfunction

  function automatic logic [PERM_W-1:0] slot_of(int unsigned i);
    return perm_reg[i*PERM_W +: PERM_W];
  endfunction

  function automatic void clear_block();
    slot_mask = '0;
    fill = 0;
  endfunction

  function automatic void queue_word(logic [POS_W-1:0] pos, logic signed [REF_W-1:0] rid,
                                     logic last, status_t st);
    result_word_t w;
    w.pos = pos;
    w.rid = rid;
    w.last = last;
    w.st = st;
    permuted_words.push_back(w);
  endfunction

  function automatic logic signed [REF_W-1:0] remap_ref_id(logic signed [REF_W-1:0] rid,
                                                          int unsigned n);
    int unsigned r;
    int v;
    if (rid < 0) return rid;
    r = int'(rid) % n;
    v = int'(rid) - int'(r) + int'(slot_of(r));
    if (v > 65535) v = 65535;
    return v[REF_W-1:0];
  endfunction

  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [MAP_W-1:0] value);
    if (idx == REG_BLOCK_LEN) blk_len_reg = value[BLEN_W-1:0];
    else if (idx == REG_PERM_MAP) perm_reg = value;
    clear_block();
  endfunction

  function automatic void gather_item(logic [POS_W-1:0] pos, logic signed [REF_W-1:0] rid,
                                      logic fin);
    int unsigned n;
    logic [PERM_W-1:0] slot;
    int unsigned j;
    n = eff_len();
    if (fill >= n) clear_block();
    slot = slot_of(fill);
    if (slot >= n || slot_mask[slot]) begin
      clear_block();
      queue_word(POS_NONE, REF_NONE, 1'b1, ST_BAD_PERM);
      return;
    end
    store_pos[slot] = pos;
    store_ref[slot] = rid;
    slot_mask[slot] = 1'b1;
    fill++;
    if (fill == n) begin
      for (j = 0; j < n; j++)
        queue_word(store_pos[j], remap_ref_id(store_ref[j], n), j + 1 == n, ST_OK);
      clear_block();
    end else if (fin) begin
      clear_block();
      queue_word(POS_NONE, REF_NONE, 1'b1, ST_NOT_DIV);
    end
  endfunction

  // mostly back to back, now and then a long hole
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [REF_W-1:0] pick_ref_id();
    int unsigned r;
    logic [REF_MAG_W-1:0] mag;
    r = $urandom_range(0, 9);
    mag = REF_MAG_W'($urandom);
    if (r == 0) return REF_NONE;
    if (r == 1) return {1'b1, mag};
    if (r == 2) return REF_W'(65535 - $urandom_range(0, 15));
    return {1'b0, mag};
  endfunction

  // random valid permutation of the first n entries, junk above them
  function automatic logic [MAP_W-1:0] make_perm(int unsigned n);
    logic [PERM_W-1:0] slots [SLOTS];
    logic [PERM_W-1:0] t;
    logic [MAP_W-1:0] m;
    int j;
    int k;
    for (j = 0; j < SLOTS; j++) slots[j] = PERM_W'(j);
    for (j = int'(n) - 1; j > 0; j--) begin
      k = $urandom_range(0, j);
      t = slots[j];
      slots[j] = slots[k];
      slots[k] = t;
    end
    m = {$urandom, $urandom};
    for (j = 0; j < int'(n); j++) m[j*PERM_W +: PERM_W] = slots[j];
    return m;
  endfunction

  task automatic send_item(input logic [POS_W-1:0] pos, input logic signed [REF_W-1:0] rid,
                           input logic fin);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.position_id <= pos;
    in_ch.ref_id      <= rid;
    in_ch.stream_end  <= fin;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    gather_item(pos, rid, fin);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MAP_W-1:0] value);
    repeat (1 + pick_gap()) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    apply_reg_write(idx, value);
    reg_writes++;
  endtask

  // drain all pending words, then give a block with no word due time to settle
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (permuted_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_item(32'h0000_0000, REF_NONE, 1'b0);
    send_item(32'hFFFF_FFFF, 17'sd65535, 1'b1);
    send_item(32'h1234_5678, -17'sd2, 1'b0);
    send_item($urandom, 17'sh10000, 1'b0);
  endtask

  task automatic test_saturation_and_len_zero();
    quiesce();
    write_reg(REG_BLOCK_LEN, 64'd3);
    // slots 2,0,1: ref 65535 has remainder 0 and lands past the top
    write_reg(REG_PERM_MAP, 64'hFFFF_FFFF_FFFF_F102);
    send_item($urandom, 17'sd65535, 1'b0);
    send_item($urandom, 17'sd65534, 1'b0);
    send_item($urandom, 17'sd4, 1'b1);
    quiesce();
    write_reg(REG_BLOCK_LEN, 64'd0);
    write_reg(REG_PERM_MAP, 64'h0);
    send_item($urandom, 17'sd77, 1'b1);
  endtask

  task automatic test_bad_slots();
    quiesce();
    write_reg(REG_BLOCK_LEN, 64'd4);
    write_reg(REG_PERM_MAP, 64'h0000_0000_0000_3215);
    // slot out of range, stream end on the same word adds nothing
    send_item($urandom, pick_ref_id(), 1'b1);
    quiesce();
    write_reg(REG_BLOCK_LEN, 64'd31);
    write_reg(REG_PERM_MAP, 64'hFFFF_FFFF_FFFF_FFFF);
    // second word hits a slot already taken
    send_item($urandom, pick_ref_id(), 1'b0);
    send_item($urandom, pick_ref_id(), 1'b0);
  endtask

  task automatic test_early_end();
    quiesce();
    write_reg(REG_BLOCK_LEN, 64'd4);
    write_reg(REG_PERM_MAP, make_perm(4));
    send_item($urandom, pick_ref_id(), 1'b0);
    send_item($urandom, pick_ref_id(), 1'b1);
  endtask

  task automatic test_write_clears_block();
    quiesce();
    write_reg(REG_BLOCK_LEN, 64'd2);
    write_reg(REG_PERM_MAP, make_perm(2));
    send_item($urandom, pick_ref_id(), 1'b0);
    quiesce();
    write_reg(REG_SPARE_HI, {$urandom, $urandom});
    send_item($urandom, pick_ref_id(), 1'b0);
    send_item($urandom, pick_ref_id(), 1'b0);
    send_item($urandom, pick_ref_id(), 1'b0);
    quiesce();
    write_reg(REG_BLOCK_LEN, 64'd2);
    send_item($urandom, pick_ref_id(), 1'b0);
    send_item($urandom, pick_ref_id(), 1'b0);
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned pick;
    int unsigned n;
    int unsigned nblk;
    int unsigned len;
    int unsigned k;
    int unsigned j;
    logic [BLEN_W-1:0] raw;
    logic [MAP_W-1:0] map;
    logic fin;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      quiesce();
      calm = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 19);
      if (pick == 0) raw = '0;
      else if (pick == 1) raw = BLEN_W'(16);
      else if (pick == 2) raw = BLEN_W'($urandom_range(17, 31));
      else if (pick == 3) raw = BLEN_W'(1);
      else if (pick < 6) raw = BLEN_W'($urandom_range(9, 16));
      else raw = BLEN_W'($urandom_range(2, 8));
      n = (raw == 0) ? 1 : (raw > SLOTS) ? SLOTS : 32'(raw);
      map = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom} : make_perm(n);
      if ($urandom_range(0, 5) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, {$urandom, $urandom});
      write_reg(REG_BLOCK_LEN, {$urandom, 27'b0, raw});
      write_reg(REG_PERM_MAP, map);
      nblk = $urandom_range(1, 3);
      for (k = 0; k < nblk; k++) begin
        pick = $urandom_range(0, 9);
        // a broken block: the last of up to n items carries a stream end
        len = (pick == 0) ? $urandom_range(1, n) : n;
        for (j = 0; j < len; j++) begin
          if (j + 1 == len) fin = (pick == 0) || ($urandom_range(0, 3) == 0);
          else fin = ($urandom_range(0, 31) == 0);
          send_item($urandom, pick_ref_id(), fin);
        end
        sent += len;
      end
    end
    calm = 1'b0;
  endtask

  function automatic void compare_field(string name, logic signed [63:0] want,
                                        logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    result_word_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (permuted_words.size() == 0) begin
        $error("unexpected word: position %0h ref %0d last %0b status %0d",
               out_ch.out_position, out_ch.out_ref, out_ch.block_last, out_ch.status);
        fail_count++;
      end else begin
        want = permuted_words.pop_front();
        compare_field("out_position", want.pos, out_ch.out_position);
        compare_field("out_ref", want.rid, out_ch.out_ref);
        compare_field("block_last", want.last, out_ch.block_last);
        compare_field("status", want.st, out_ch.status);
        case (want.st)
          ST_OK:       ok_words++;
          ST_BAD_PERM: bad_slot_words++;
          default:     early_end_words++;
        endcase
      end
    end
  end

  initial begin : result_sink
    int unsigned hold;
    forever begin
      hold = pick_gap();
      if (hold == 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle = 0;
      else
        idle++;
    end
    $display("Watchdog: no word moved for %0d cycles, %0d still pending",
             STALL_LIMIT, permuted_words.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    blk_len_reg = BLEN_RESET;
    perm_reg    = PERM_RESET;
    slot_mask   = '0;
    fill        = 0;
    calm        = 1'b0;
    rst               <= 1'b1;
    in_ch.valid       <= 1'b0;
    in_ch.position_id <= '0;
    in_ch.ref_id      <= '0;
    in_ch.stream_end  <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= '0;
    cfg_ch.data       <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_saturation_and_len_zero();
    test_bad_slots();
    test_early_end();
    test_write_clears_block();
    test_random_traffic();
    quiesce();

    $display("Sent %0d items over %0d register writes (block lengths 0..31, random maps).",
             items_sent, reg_writes);
    $display("Checked %0d permuted words, %0d bad-slot errors, %0d early stream ends.",
             ok_words, bad_slot_words, early_end_words);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### sim.f
src/bpr_pkg.sv
src/bpr_in_if.sv
src/bpr_out_if.sv
src/bpr_cfg_if.sv
src/bpr_rem.sv
src/bpr_store.sv
src/block_permutation_reorder.sv
src/bpr_checker.sv
dv/tb.sv
